// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/cpfl_pkg.sv =====
// ----------------------------------------------------------------------------
// Chunk pool package
// Types, codes and helpers shared by the chunk pool controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package cpfl_pkg;

   localparam int MaxChunks = 64;
   localparam int IdxW      = $clog2(MaxChunks);
   localparam int CntW      = $clog2(MaxChunks + 1);

   localparam logic [1:0] CSR_BASE  = 2'd0;
   localparam logic [1:0] CSR_SIZE  = 2'd1;
   localparam logic [1:0] CSR_COUNT = 2'd2;

   typedef enum logic [1:0] {
      KIND_ALLOC,
      KIND_FREE,
      KIND_INDEX,
      KIND_LIST
   } kind_type;

   typedef enum logic [2:0] {
      STATUS_OK,
      STATUS_EMPTY,
      STATUS_BADADDR,
      STATUS_FULL,
      STATUS_RANGE
   } status_type;

   typedef struct packed {
      kind_type    kind;
      logic [63:0] chunk_addr_in;
      logic [5:0]  chunk_index_in;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [5:0]  chunk_index_out;
      logic [63:0] chunk_addr_out;
      logic [6:0]  free_left;
      logic [6:0]  allocated_total;
      logic        last;
   } rsp_type;

   typedef enum logic [2:0] {
      RS_EMPTY,
      RS_BAD,
      RS_FULL,
      RS_RANGE,
      RS_NONE,
      RS_OK_WI,
      RS_OK_FREE,
      RS_OK_LIST
   } rsp_sel_type;

   typedef enum logic [2:0] {
      WI_HOLD,
      WI_CAP,
      WI_HEAD,
      WI_TOP,
      WI_ZERO,
      WI_INC,
      WI_DEC,
      WI_LINK
   } wi_op_type;

   typedef struct packed {
      logic        cap;
      logic        clr;
      logic        mem_rd;
      logic        pop;
      logic        div_step;
      logic        push;
      logic        walk_adv;
      logic        take_last;
      logic        mul;
      logic        add;
      logic        emit;
      rsp_sel_type sel;
      wi_op_type   wi_op;
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     free_zero;
      logic     range_bad;
      logic     div_done;
      logic     free_bad;
      logic     pool_full;
      logic     walk_done;
      logic     unmarked;
      logic     wi_zero;
      logic     scan_last;
   } sts_type;

   function automatic logic [CntW-1:0] pool_n(input logic [6:0] count);
      logic [CntW-1:0] n;
      if (count == 7'd0) begin
         n = CntW'(1);
      end else if (32'(count) > MaxChunks) begin
         n = CntW'(MaxChunks);
      end else begin
         n = CntW'(count);
      end
      return n;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/cpfl_ctrl.sv =====
// ----------------------------------------------------------------------------
// Chunk pool controller
// Sequences each request through the datapath by command and status signals.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module cpfl_ctrl (
   input  wire              clock,
   input  wire              reset,
   input  wire              start,
   output logic             busy,
   input  cpfl_pkg::sts_type sts,
   output cpfl_pkg::cmd_type cmd
);
   import cpfl_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DECODE,
      ST_A_RD,
      ST_A_POP,
      ST_MUL,
      ST_ADD,
      ST_OUT,
      ST_DIV,
      ST_F_CHK,
      ST_F_OUT,
      ST_L_WALK,
      ST_L_ADV,
      ST_L_FIND,
      ST_L_SCAN,
      ST_L_ADD,
      ST_L_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;

   assign busy = busy_ff;

   always_comb begin
      cmd      = '0;
      cmd.sel  = RS_NONE;
      cmd.wi_op = WI_HOLD;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.cap   = 1'b1;
               cmd.wi_op = WI_CAP;
               state_in  = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (sts.kind)
               KIND_ALLOC: begin
                  if (sts.free_zero) begin
                     cmd.emit = 1'b1;
                     cmd.sel  = RS_EMPTY;
                     state_in = ST_IDLE;
                  end else begin
                     state_in = ST_A_RD;
                  end
               end
               KIND_FREE: state_in = ST_DIV;
               KIND_INDEX: begin
                  if (sts.range_bad) begin
                     cmd.emit = 1'b1;
                     cmd.sel  = RS_RANGE;
                     state_in = ST_IDLE;
                  end else begin
                     state_in = ST_MUL;
                  end
               end
               default: begin
                  cmd.clr   = 1'b1;
                  cmd.wi_op = WI_HEAD;
                  state_in  = ST_L_WALK;
               end
            endcase
         end
         ST_A_RD: begin
            cmd.mem_rd = 1'b1;
            state_in   = ST_A_POP;
         end
         ST_A_POP: begin
            cmd.pop  = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            cmd.add  = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            cmd.emit = 1'b1;
            cmd.sel  = RS_OK_WI;
            state_in = ST_IDLE;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) begin
               state_in = ST_F_CHK;
            end
         end
         ST_F_CHK: begin
            if (sts.free_bad) begin
               cmd.emit = 1'b1;
               cmd.sel  = RS_BAD;
               state_in = ST_IDLE;
            end else if (sts.pool_full) begin
               cmd.emit = 1'b1;
               cmd.sel  = RS_FULL;
               state_in = ST_IDLE;
            end else begin
               cmd.push = 1'b1;
               state_in = ST_F_OUT;
            end
         end
         ST_F_OUT: begin
            cmd.emit = 1'b1;
            cmd.sel  = RS_OK_FREE;
            state_in = ST_IDLE;
         end
         ST_L_WALK: begin
            if (sts.walk_done) begin
               cmd.wi_op = WI_TOP;
               state_in  = ST_L_FIND;
            end else begin
               cmd.mem_rd = 1'b1;
               state_in   = ST_L_ADV;
            end
         end
         ST_L_ADV: begin
            cmd.walk_adv = 1'b1;
            cmd.wi_op    = WI_LINK;
            state_in     = ST_L_WALK;
         end
         ST_L_FIND: begin
            if (sts.unmarked) begin
               cmd.take_last = 1'b1;
               cmd.wi_op     = WI_ZERO;
               state_in      = ST_L_SCAN;
            end else if (sts.wi_zero) begin
               cmd.emit = 1'b1;
               cmd.sel  = RS_NONE;
               state_in = ST_IDLE;
            end else begin
               cmd.wi_op = WI_DEC;
            end
         end
         ST_L_SCAN: begin
            if (sts.unmarked) begin
               cmd.mul  = 1'b1;
               state_in = ST_L_ADD;
            end else begin
               cmd.wi_op = WI_INC;
            end
         end
         ST_L_ADD: begin
            cmd.add  = 1'b1;
            state_in = ST_L_OUT;
         end
         ST_L_OUT: begin
            cmd.emit = 1'b1;
            cmd.sel  = RS_OK_LIST;
            if (sts.scan_last) begin
               state_in = ST_IDLE;
            end else begin
               cmd.wi_op = WI_INC;
               state_in  = ST_L_SCAN;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != ST_IDLE);
      end
   end

   `ASSERT_NEXT(a_emit_ends, clock, reset, cmd.emit && state_ff != ST_L_OUT, state_ff == ST_IDLE)
   `ASSERT_NEXT(a_list_more, clock, reset, cmd.emit && !sts.scan_last && state_ff == ST_L_OUT, state_ff == ST_L_SCAN)

endmodule

`default_nettype wire

// ===== rtl/cpfl_dp.sv =====
// ----------------------------------------------------------------------------
// Chunk pool datapath
// Registers, next-link memory, free marks, divider and address unit.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module cpfl_dp (
   input  wire               clock,
   input  wire               reset,
   input  wire               csr_we,
   input  wire  [1:0]        csr_index,
   input  wire  [63:0]       csr_wdata,
   input  cpfl_pkg::req_type req_data,
   input  cpfl_pkg::cmd_type cmd,
   output cpfl_pkg::sts_type sts,
   output logic              rsp_strobe,
   output cpfl_pkg::rsp_type rsp_data
);
   import cpfl_pkg::*;

   logic [63:0]      base_ff;
   logic [31:0]      size_ff;
   logic [6:0]       cin_ff;
   logic [IdxW-1:0]  head_ff;
   logic [CntW-1:0]  free_ff;
   logic [MaxChunks-1:0] valid_ff;
   logic [MaxChunks-1:0] mark_ff;
   logic [IdxW-1:0]  link_mem [MaxChunks];
   logic [IdxW-1:0]  link_q_ff;
   logic             rd_valid_ff;
   logic [IdxW-1:0]  rd_addr_ff;
   req_type          req_ff;
   logic [IdxW-1:0]  wi_ff;
   logic [CntW-1:0]  cnt_ff;
   logic [IdxW-1:0]  last_ff;
   logic [63:0]      rem_ff;
   logic             borrow_ff;
   logic             ovf_ff;
   logic [6:0]       q_ff;
   logic [2:0]       step_ff;
   logic [37:0]      prod_ff;
   logic [63:0]      addr_ff;
   logic             strobe_ff;
   rsp_type          rsp_ff;

   logic [CntW-1:0]  n_w;
   logic [CntW-1:0]  n_new;
   logic [31:0]      size_eff;
   logic [IdxW-1:0]  link_val;
   logic [63:0]      shifted;
   logic             ge;
   logic             cfg_hit;
   rsp_type          rsp_in;

   assign n_w      = pool_n(cin_ff);
   assign size_eff = (size_ff == 32'd0) ? 32'd1 : size_ff;
   assign link_val = rd_valid_ff ? link_q_ff :
                     ((rd_addr_ff == '0) ? '0 : rd_addr_ff - IdxW'(1));
   assign shifted  = 64'(size_eff) << step_ff;
   assign ge       = rem_ff >= shifted;
   assign cfg_hit  = csr_we && (csr_index <= CSR_COUNT);
   assign n_new    = (csr_index == CSR_COUNT) ? pool_n(csr_wdata[6:0]) : n_w;

   assign sts.kind      = req_ff.kind;
   assign sts.free_zero = (free_ff == '0);
   assign sts.range_bad = (CntW'(req_ff.chunk_index_in) >= n_w);
   assign sts.div_done  = (step_ff == 3'd0);
   assign sts.free_bad  = borrow_ff || ovf_ff || (rem_ff != 64'd0) || (q_ff >= n_w);
   assign sts.pool_full = (free_ff >= n_w);
   assign sts.walk_done = (cnt_ff == free_ff);
   assign sts.unmarked  = !mark_ff[wi_ff];
   assign sts.wi_zero   = (wi_ff == '0);
   assign sts.scan_last = (wi_ff == last_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= 64'd0;
         size_ff  <= 32'd64;
         cin_ff   <= 7'd64;
         head_ff  <= IdxW'(MaxChunks - 1);
         free_ff  <= CntW'(MaxChunks);
         valid_ff <= '0;
      end else if (cfg_hit) begin
         case (csr_index)
            CSR_BASE: base_ff <= csr_wdata;
            CSR_SIZE: size_ff <= csr_wdata[31:0];
            default:  cin_ff  <= csr_wdata[6:0];
         endcase
         head_ff  <= IdxW'(n_new - CntW'(1));
         free_ff  <= n_new;
         valid_ff <= '0;
      end else if (cmd.pop) begin
         head_ff <= link_val;
         free_ff <= free_ff - CntW'(1);
      end else if (cmd.push) begin
         head_ff            <= q_ff[IdxW-1:0];
         free_ff            <= free_ff + CntW'(1);
         valid_ff[q_ff[IdxW-1:0]] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         link_mem[q_ff[IdxW-1:0]] <= head_ff;
      end
      if (cmd.mem_rd) begin
         link_q_ff   <= link_mem[wi_ff];
         rd_valid_ff <= valid_ff[wi_ff];
         rd_addr_ff  <= wi_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mark_ff <= '0;
      end else if (cmd.clr) begin
         mark_ff <= '0;
      end else if (cmd.walk_adv) begin
         mark_ff[wi_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cap) begin
         req_ff <= req_data;
         {borrow_ff, rem_ff} <= {1'b0, req_data.chunk_addr_in} - {1'b0, base_ff};
         step_ff <= 3'd7;
         q_ff    <= 7'd0;
         ovf_ff  <= 1'b0;
      end else if (cmd.div_step) begin
         if (step_ff == 3'd7) begin
            ovf_ff <= ge;
         end else if (ge) begin
            rem_ff <= rem_ff - shifted;
            q_ff   <= q_ff | (7'd1 << step_ff);
         end
         step_ff <= step_ff - 3'd1;
      end
      if (cmd.clr) begin
         cnt_ff <= '0;
      end else if (cmd.walk_adv) begin
         cnt_ff <= cnt_ff + CntW'(1);
      end
      if (cmd.take_last) begin
         last_ff <= wi_ff;
      end
      case (cmd.wi_op)
         WI_CAP:  wi_ff <= (req_data.kind == KIND_ALLOC) ? head_ff
                                                         : req_data.chunk_index_in;
         WI_HEAD: wi_ff <= head_ff;
         WI_TOP:  wi_ff <= IdxW'(n_w - CntW'(1));
         WI_ZERO: wi_ff <= '0;
         WI_INC:  wi_ff <= wi_ff + IdxW'(1);
         WI_DEC:  wi_ff <= wi_ff - IdxW'(1);
         WI_LINK: wi_ff <= link_val;
         default: wi_ff <= wi_ff;
      endcase
      if (cmd.mul) begin
         prod_ff <= 38'(size_eff) * 38'(wi_ff);
      end
      if (cmd.add) begin
         addr_ff <= base_ff + 64'(prod_ff);
      end
   end

   always_comb begin
      rsp_in                 = '0;
      rsp_in.status          = STATUS_OK;
      rsp_in.free_left       = free_ff;
      rsp_in.allocated_total = n_w - free_ff;
      rsp_in.last            = 1'b1;
      case (cmd.sel)
         RS_EMPTY: rsp_in.status = STATUS_EMPTY;
         RS_BAD:   rsp_in.status = STATUS_BADADDR;
         RS_FULL:  rsp_in.status = STATUS_FULL;
         RS_RANGE: begin
            rsp_in.status          = STATUS_RANGE;
            rsp_in.chunk_index_out = wi_ff;
         end
         RS_OK_WI: begin
            rsp_in.chunk_index_out = wi_ff;
            rsp_in.chunk_addr_out  = addr_ff;
         end
         RS_OK_FREE: begin
            rsp_in.chunk_index_out = q_ff[IdxW-1:0];
            rsp_in.chunk_addr_out  = req_ff.chunk_addr_in;
         end
         RS_OK_LIST: begin
            rsp_in.chunk_index_out = wi_ff;
            rsp_in.chunk_addr_out  = addr_ff;
            rsp_in.last            = (wi_ff == last_ff);
         end
         default: rsp_in.status = STATUS_OK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.emit;
      end
      if (cmd.emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   `ASSERT_IMPLY(a_free_le_n, clock, reset, 1'b1, free_ff <= n_w)
   `ASSERT_IMPLY(a_head_in_pool, clock, reset, free_ff != '0, CntW'(head_ff) < n_w)

endmodule

`default_nettype wire

// ===== rtl/chunk_pool_free_list_manager.sv =====
// ----------------------------------------------------------------------------
// Chunk pool free-list manager
// LIFO free list of equal-size chunks with alloc, free, address and list.
// ----------------------------------------------------------------------------
//   Channel   Handshake           Payload
//   request   start / busy        req_data
//   result    rsp_strobe          rsp_data
//   config    csr_we              csr_index, csr_wdata
//
// Alloc, index and free requests each end in one result beat; a free's divider
// retires one quotient bit a cycle. An empty pool or a range error answers straight
// from decode, a bad or full free once the division is done. A list walks the F free
// chunks through the next-link memory, then gives one beat for each of the A
// allocated chunks, or one beat if none is. Reset is synchronous and restores every
// chunk to free. Each result beat is shown for one cycle; the receiver cannot stall.
`default_nettype none

module chunk_pool_free_list_manager (
   input  wire               clock,
   input  wire               reset,
   input  wire               start,
   output logic              busy,
   input  cpfl_pkg::req_type req_data,
   output logic              rsp_strobe,
   output cpfl_pkg::rsp_type rsp_data,
   input  wire               csr_we,
   input  wire  [1:0]        csr_index,
   input  wire  [63:0]       csr_wdata
);
   import cpfl_pkg::*;

   cmd_type cmd;
   sts_type sts;

   cpfl_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   cpfl_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_data   (req_data),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire
